// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the checker file of the display driver.
// Each macro needs signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ssd_pkg.sv -----
// Package for the multiplexed seven-segment display driver.
// Holds command codes, the internal operation type, queue entry types and segment tables.
`default_nettype none

package ssd_pkg;

    localparam int QUEUE_DEPTH  = 2;
    localparam int NUM_WIDTH    = 32;
    localparam int ENABLE_WIDTH = 6;
    localparam int SEG_WIDTH    = 8;
    localparam int CODE_WIDTH   = 8;
    localparam int CMD_WIDTH    = 3;

    localparam logic [CODE_WIDTH-1:0] BLANK_CODE = 8'h80;
    localparam logic [SEG_WIDTH-1:0]  POINT_BIT  = 8'h20;

    localparam logic [CMD_WIDTH-1:0] CMD_TICK       = 3'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_SET_NUMBER = 3'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_PUSH       = 3'd2;
    localparam logic [CMD_WIDTH-1:0] CMD_POP        = 3'd3;
    localparam logic [CMD_WIDTH-1:0] CMD_CLEAR      = 3'd4;
    localparam logic [CMD_WIDTH-1:0] CMD_LOAD       = 3'd5;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_SET_NUMBER,
        OP_PUSH,
        OP_POP,
        OP_CLEAR,
        OP_LOAD,
        OP_MODE_ONLY
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [NUM_WIDTH-1:0]  number_value;
        logic [CODE_WIDTH-1:0] symbol_code;
        logic                  first_of_load;
        logic                  mode_select;
        logic                  mode_write;
    } queue_entry_t;

    typedef struct packed {
        logic         push;
        queue_entry_t entry;
    } queue_write_t;

    typedef struct packed {
        logic         valid;
        queue_entry_t entry;
    } queue_read_t;

    typedef enum logic {
        BK_IDLE,
        BK_CONVERT
    } back_state_t;

    // Segment byte of a decimal digit; codes above nine wrap as a remainder by ten.
    function automatic logic [SEG_WIDTH-1:0] digit_pattern(input logic [3:0] digit);
        logic [SEG_WIDTH-1:0] seg;
        unique case (digit)
            4'd0, 4'd10: seg = 8'hcf;
            4'd1, 4'd11: seg = 8'h0c;
            4'd2, 4'd12: seg = 8'h5b;
            4'd3, 4'd13: seg = 8'h5d;
            4'd4, 4'd14: seg = 8'h9c;
            4'd5, 4'd15: seg = 8'hd5;
            4'd6:        seg = 8'hd7;
            4'd7:        seg = 8'h4c;
            4'd8:        seg = 8'hdf;
            4'd9:        seg = 8'hdd;
            default:     seg = 8'hcf;
        endcase
        return seg;
    endfunction

    // Segment byte of an info code; anything that is neither a digit nor a known symbol is blank.
    function automatic logic [SEG_WIDTH-1:0] info_pattern(input logic [CODE_WIDTH-1:0] code);
        logic [SEG_WIDTH-1:0] seg;
        if (code < 8'd10) begin
            seg = digit_pattern(code[3:0]);
        end else begin
            unique case (code)
                8'h81:   seg = 8'hc3;
                8'h82:   seg = 8'hc8;
                8'h83:   seg = 8'h98;
                8'h84:   seg = 8'hd0;
                8'h85:   seg = 8'h58;
                default: seg = 8'h00;
            endcase
        end
        return seg;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ssd_front.sv -----
// Front end of the display driver: accepts commands and turns them into queue entries.
// Depends on ssd_pkg.
`default_nettype none

module ssd_front (
    input  wire logic                          start,
    input  wire logic                          queue_full,
    input  wire logic [ssd_pkg::CMD_WIDTH-1:0] command,
    input  wire logic [ssd_pkg::NUM_WIDTH-1:0] number_value,
    input  wire logic [ssd_pkg::CODE_WIDTH-1:0] symbol_code,
    input  wire logic                          first_of_load,
    input  wire logic                          mode_select,
    input  wire logic                          mode_write,
    output ssd_pkg::queue_write_t              wr
);
    import ssd_pkg::*;

    op_t op;

    always_comb
    begin
        unique case (command)
            CMD_TICK:       op = OP_TICK;
            CMD_SET_NUMBER: op = OP_SET_NUMBER;
            CMD_PUSH:       op = OP_PUSH;
            CMD_POP:        op = OP_POP;
            CMD_CLEAR:      op = OP_CLEAR;
            CMD_LOAD:       op = OP_LOAD;
            default:        op = OP_MODE_ONLY;
        endcase
    end

    always_comb
    begin
        wr.entry.op            = op;
        wr.entry.number_value  = number_value;
        wr.entry.symbol_code   = symbol_code;
        wr.entry.first_of_load = first_of_load;
        wr.entry.mode_select   = mode_select;
        wr.entry.mode_write    = mode_write;
        // An unused command without a mode write has no effect, so it is dropped here.
        wr.push = start && !queue_full && ((op != OP_MODE_ONLY) || mode_write);
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ssd_queue.sv -----
// Short in-order queue between the front and back ends of the display driver.
// Depends on ssd_pkg.
`default_nettype none

module ssd_queue (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire ssd_pkg::queue_write_t wr,
    input  wire logic         pop,
    output ssd_pkg::queue_read_t  rd,
    output logic              full
);
    import ssd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    queue_entry_t     entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr.push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({wr.push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.push) begin
            entry_reg[wr_ptr_reg] <= wr.entry;
        end
    end

    assign rd.valid = (count_reg != '0);
    assign rd.entry = entry_reg[rd_ptr_reg];
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));

endmodule

`default_nettype wire

// ----- hw/rtl/ssd_back.sv -----
// Back end of the display driver: holds the digit and symbol stores and executes queued commands.
// Depends on ssd_pkg; the number conversion yields one decimal digit per cycle by reciprocal
// multiplication.
`default_nettype none

module ssd_back #(
    parameter int DIGIT_COUNT = 6
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire ssd_pkg::queue_read_t             rd,
    output logic                                  pop,
    output logic                                  result_strobe,
    output logic [ssd_pkg::ENABLE_WIDTH-1:0]      digit_enable,
    output logic [ssd_pkg::SEG_WIDTH-1:0]         segment_pattern,
    output logic                                  display_mode
);
    import ssd_pkg::*;

    localparam int SCAN_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int LOAD_W = $clog2(DIGIT_COUNT + 1);

    // floor(n / 10) equals (n * 0xcccccccd) >> 35 for every 32-bit n.
    localparam logic [NUM_WIDTH-1:0] TENTH_RECIP = 32'hcccc_cccd;
    localparam int                   RECIP_SHIFT = 35;

    back_state_t state_reg, state_next;

    logic [3:0]            digits_reg  [DIGIT_COUNT];
    logic [3:0]            digits_next [DIGIT_COUNT];
    logic [CODE_WIDTH-1:0] symbols_reg  [DIGIT_COUNT];
    logic [CODE_WIDTH-1:0] symbols_next [DIGIT_COUNT];
    logic [SCAN_W-1:0]     scan_reg, scan_next;
    logic                  mode_reg, mode_next;
    logic [LOAD_W-1:0]     load_count_reg, load_count_next;
    logic [NUM_WIDTH-1:0]  value_reg, value_next;
    logic [SCAN_W-1:0]     digit_cnt_reg, digit_cnt_next;
    logic                  strobe_reg, strobe_next;
    logic [ENABLE_WIDTH-1:0] enable_reg, enable_next;
    logic [SEG_WIDTH-1:0]  seg_reg, seg_next;
    logic                  disp_reg, disp_next;

    logic                  converting;
    logic                  mode_now;
    logic [7:0]            scan_onehot;
    logic [2*NUM_WIDTH-1:0] product;
    logic [NUM_WIDTH-1:0]  quotient;
    logic [NUM_WIDTH-1:0]  remainder;
    logic [CODE_WIDTH-1:0] load_base [DIGIT_COUNT];
    logic [LOAD_W-1:0]     load_cnt;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (rd.valid && (rd.entry.op == OP_SET_NUMBER)) begin
                    state_next = BK_CONVERT;
                end
            end
            BK_CONVERT:
            begin
                if (digit_cnt_reg == SCAN_W'(DIGIT_COUNT - 1)) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // State machine outputs.
    always_comb
    begin
        pop        = 1'b0;
        converting = 1'b0;
        unique case (state_reg)
            BK_IDLE:    pop = rd.valid;
            BK_CONVERT: converting = 1'b1;
            default:    pop = 1'b0;
        endcase
    end

    // Datapath.
    always_comb
    begin
        digits_next     = digits_reg;
        symbols_next    = symbols_reg;
        scan_next       = scan_reg;
        mode_next       = mode_reg;
        load_count_next = load_count_reg;
        value_next      = value_reg;
        digit_cnt_next  = digit_cnt_reg;
        strobe_next     = 1'b0;
        enable_next     = enable_reg;
        seg_next        = seg_reg;
        disp_next       = disp_reg;
        mode_now        = mode_reg;
        scan_onehot     = 8'(1) << scan_reg;
        load_cnt        = load_count_reg;
        product         = {{NUM_WIDTH{1'b0}}, value_reg} * {{NUM_WIDTH{1'b0}}, TENTH_RECIP};
        quotient        = NUM_WIDTH'(product >> RECIP_SHIFT);
        remainder       = value_reg - ((quotient << 3) + (quotient << 1));
        for (int i = 0; i < DIGIT_COUNT; i++) begin
            load_base[i] = symbols_reg[i];
        end

        if (pop) begin
            // The mode write takes effect before the command itself.
            if (rd.entry.mode_write) begin
                mode_now = rd.entry.mode_select;
            end
            mode_next = mode_now;
            case (rd.entry.op)
                OP_TICK:
                begin
                    strobe_next = 1'b1;
                    enable_next = scan_onehot[ENABLE_WIDTH-1:0];
                    disp_next   = mode_now;
                    if (!mode_now) begin
                        seg_next = digit_pattern(digits_reg[scan_reg]);
                        if (scan_reg == SCAN_W'(1)) begin
                            seg_next = seg_next | POINT_BIT;
                        end
                    end else begin
                        seg_next = info_pattern(symbols_reg[scan_reg]);
                    end
                    scan_next = (scan_reg == SCAN_W'(DIGIT_COUNT - 1)) ?
                                '0 : scan_reg + SCAN_W'(1);
                end
                OP_SET_NUMBER:
                begin
                    value_next     = rd.entry.number_value;
                    digit_cnt_next = '0;
                end
                OP_PUSH:
                begin
                    for (int i = 1; i < DIGIT_COUNT; i++) begin
                        symbols_next[i] = symbols_reg[i-1];
                    end
                    symbols_next[0] = rd.entry.symbol_code;
                end
                OP_POP:
                begin
                    for (int i = 0; i < DIGIT_COUNT - 1; i++) begin
                        symbols_next[i] = symbols_reg[i+1];
                    end
                    symbols_next[DIGIT_COUNT-1] = BLANK_CODE;
                end
                OP_CLEAR:
                begin
                    for (int i = 0; i < DIGIT_COUNT; i++) begin
                        symbols_next[i] = BLANK_CODE;
                    end
                end
                OP_LOAD:
                begin
                    // The first element of a load starts from an empty store and a zero count.
                    if (rd.entry.first_of_load) begin
                        for (int i = 0; i < DIGIT_COUNT; i++) begin
                            load_base[i] = BLANK_CODE;
                        end
                        load_cnt = '0;
                    end
                    symbols_next    = load_base;
                    load_count_next = load_cnt;
                    if (load_cnt < LOAD_W'(DIGIT_COUNT)) begin
                        for (int i = 1; i < DIGIT_COUNT; i++) begin
                            symbols_next[i] = load_base[i-1];
                        end
                        symbols_next[0] = rd.entry.symbol_code;
                        load_count_next = load_cnt + LOAD_W'(1);
                    end
                end
                default:
                begin
                    mode_next = mode_now;
                end
            endcase
        end

        if (converting) begin
            // One decimal digit per cycle, least significant first. Each new digit enters
            // at the top and moves down, so after the last step digit 0 sits at position 0.
            // Digits beyond the display are never produced.
            for (int i = 0; i < DIGIT_COUNT - 1; i++) begin
                digits_next[i] = digits_reg[i+1];
            end
            digits_next[DIGIT_COUNT-1] = remainder[3:0];
            value_next     = quotient;
            digit_cnt_next = digit_cnt_reg + SCAN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= BK_IDLE;
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                digits_reg[i]  <= 4'd0;
                symbols_reg[i] <= BLANK_CODE;
            end
            scan_reg       <= '0;
            mode_reg       <= 1'b0;
            load_count_reg <= '0;
            digit_cnt_reg  <= '0;
            strobe_reg     <= 1'b0;
            enable_reg     <= '0;
            seg_reg        <= '0;
            disp_reg       <= 1'b0;
        end else begin
            state_reg      <= state_next;
            digits_reg     <= digits_next;
            symbols_reg    <= symbols_next;
            scan_reg       <= scan_next;
            mode_reg       <= mode_next;
            load_count_reg <= load_count_next;
            digit_cnt_reg  <= digit_cnt_next;
            strobe_reg     <= strobe_next;
            enable_reg     <= enable_next;
            seg_reg        <= seg_next;
            disp_reg       <= disp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign result_strobe   = strobe_reg;
    assign digit_enable    = enable_reg;
    assign segment_pattern = seg_reg;
    assign display_mode    = disp_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/multiplexed_seven_segment_driver_unit.sv -----
// A tick is written into a queue entry register and, once the back end pops it, into the
// registered result with its strobe; the receiver cannot stall.
// Throughput: the back end retires one command per cycle while idle; a set number loads the value,
// then holds the back end while it produces one decimal digit per cycle for each of the six digits.
// A two-entry queue lets start be taken while the back end works; busy is high while it is full.
// Reset is asynchronous and active low: digits zero, symbols blank, number mode, scan at digit 0.
`default_nettype none

module multiplexed_seven_segment_driver_unit #(
    parameter int DIGIT_COUNT = 6
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [ssd_pkg::CMD_WIDTH-1:0]   command,
    input  wire logic [ssd_pkg::NUM_WIDTH-1:0]   number_value,
    input  wire logic [ssd_pkg::CODE_WIDTH-1:0]  symbol_code,
    input  wire logic                            first_of_load,
    input  wire logic                            mode_select,
    input  wire logic                            mode_write,
    output logic                                 result_strobe,
    output logic [ssd_pkg::ENABLE_WIDTH-1:0]     digit_enable,
    output logic [ssd_pkg::SEG_WIDTH-1:0]        segment_pattern,
    output logic                                 display_mode
);
    import ssd_pkg::*;

    // The front end decodes each transaction into an internal operation and drops
    // unused commands that carry no mode write, since they change nothing.
    queue_write_t q_wr;
    queue_read_t  q_rd;
    logic         q_full;
    logic         q_pop;

    ssd_front u_front (
        .start         (start),
        .queue_full    (q_full),
        .command       (command),
        .number_value  (number_value),
        .symbol_code   (symbol_code),
        .first_of_load (first_of_load),
        .mode_select   (mode_select),
        .mode_write    (mode_write),
        .wr            (q_wr)
    );

    // The queue keeps commands in order, so a tick always sees every store update
    // that was accepted before it.
    ssd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .pop   (q_pop),
        .rd    (q_rd),
        .full  (q_full)
    );

    // The back end owns all display state. A tick produces the one-hot enable and the
    // segment byte of the current digit in registers that hold until the next tick;
    // the segment byte is meant to be shifted out least significant bit first.
    ssd_back #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .rd              (q_rd),
        .pop             (q_pop),
        .result_strobe   (result_strobe),
        .digit_enable    (digit_enable),
        .segment_pattern (segment_pattern),
        .display_mode    (display_mode)
    );

    assign busy = q_full;

endmodule

`default_nettype wire

// ----- hw/rtl/ssd_checker.sv -----
// Port-level checker for the display driver, attached to the top level by a bind.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ssd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       result_strobe,
    input wire logic [5:0] digit_enable,
    input wire logic [7:0] segment_pattern,
    input wire logic       display_mode
);

    `SSD_ASSERT_IMP(a_enable_onehot, result_strobe, $onehot0(digit_enable), "digit enable is not one-hot")
    `SSD_ASSERT_IMP(a_point_digit1, result_strobe && !display_mode && digit_enable[1], segment_pattern[5], "digit one lacks the point in number mode")
    `SSD_ASSERT_IMP(a_no_lone_point, result_strobe, segment_pattern != 8'h20, "segment byte holds only the point")
    `SSD_ASSERT_NEXT(a_mode_hold, 1'b1, result_strobe || $stable(display_mode), "display mode changed without a result")

endmodule

bind multiplexed_seven_segment_driver_unit ssd_checker u_ssd_checker (.*);

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the multiplexed seven-segment display driver unit.
// Depends on ssd_pkg for command codes and widths; predicts every scan result internally.
`default_nettype none

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ssd_pkg::*;

    // The block is built with its default six digits.
    localparam int DIGITS = 6;

    // Command codes 6 and 7 are not decoded by the block; only a mode write acts.
    localparam logic [CMD_WIDTH-1:0] CMD_SPARE_LOW  = 3'd6;
    localparam logic [CMD_WIDTH-1:0] CMD_SPARE_HIGH = 3'd7;

    // First and last of the named symbol codes (blank through right arrow).
    localparam logic [CODE_WIDTH-1:0] SYMBOL_FIRST = 8'h80;
    localparam logic [CODE_WIDTH-1:0] SYMBOL_LAST  = 8'h85;

    localparam int ITEM_GOAL     = 1350;
    localparam int DRAIN_EVERY   = 250;
    // This covers any command left over, even a set number that still occupies the back end.
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 1_000_000;

    // One expected scan result: the lit digit, its segment byte and the mode shown.
    typedef struct packed {
        logic [ENABLE_WIDTH-1:0] enable;
        logic [SEG_WIDTH-1:0]    segments;
        logic                    mode;
    } scan_t;

    // The scoreboard keeps a private copy of the display state. Every accepted
    // transaction updates it, and every tick adds the scan it must produce.
    class display_scoreboard #(int DIGIT_SLOTS = 6);

        scan_t                 expected_scans[$];
        logic [3:0]            digit_store[DIGIT_SLOTS];
        logic [CODE_WIDTH-1:0] symbol_store[DIGIT_SLOTS];
        int unsigned           scan_index;
        logic                  mode_flag;
        int unsigned           load_count;
        int unsigned           mismatches;
        int unsigned           scans_checked;
        int unsigned           command_counts[8];

        function new();
            foreach (digit_store[i]) digit_store[i] = 4'd0;
            clear_symbols();
            scan_index    = 0;
            mode_flag     = 1'b0;
            load_count    = 0;
            mismatches    = 0;
            scans_checked = 0;
            foreach (command_counts[i]) command_counts[i] = 0;
        endfunction

        function void clear_symbols();
            foreach (symbol_store[i]) symbol_store[i] = BLANK_CODE;
        endfunction

        // The newest symbol goes to position 0; the oldest falls off the top.
        function void shift_in(logic [CODE_WIDTH-1:0] code);
            for (int i = DIGIT_SLOTS - 1; i > 0; i--) symbol_store[i] = symbol_store[i - 1];
            symbol_store[0] = code;
        endfunction

        function logic [SEG_WIDTH-1:0] digit_segments(logic [3:0] digit);
            logic [SEG_WIDTH-1:0] seg;
            case (digit)
                4'd0:    seg = 8'hcf;
                4'd1:    seg = 8'h0c;
                4'd2:    seg = 8'h5b;
                4'd3:    seg = 8'h5d;
                4'd4:    seg = 8'h9c;
                4'd5:    seg = 8'hd5;
                4'd6:    seg = 8'hd7;
                4'd7:    seg = 8'h4c;
                4'd8:    seg = 8'hdf;
                4'd9:    seg = 8'hdd;
                default: seg = 8'h00;
            endcase
            return seg;
        endfunction

        // Unknown codes show nothing at all.
        function logic [SEG_WIDTH-1:0] symbol_segments(logic [CODE_WIDTH-1:0] code);
            logic [SEG_WIDTH-1:0] seg;
            if (code < 8'd10) begin
                seg = digit_segments(code[3:0]);
            end else begin
                case (code)
                    8'h81:   seg = 8'hc3;
                    8'h82:   seg = 8'hc8;
                    8'h83:   seg = 8'h98;
                    8'h84:   seg = 8'hd0;
                    8'h85:   seg = 8'h58;
                    default: seg = 8'h00;
                endcase
            end
            return seg;
        endfunction

        function void note_command(logic [CMD_WIDTH-1:0] cmd, logic [NUM_WIDTH-1:0] value,
                                   logic [CODE_WIDTH-1:0] code, logic first,
                                   logic sel, logic wr);
            scan_t                scan;
            logic [NUM_WIDTH-1:0] rest;
            command_counts[cmd]++;
            // The mode write takes effect before the command itself.
            if (wr) mode_flag = sel;
            case (cmd)
                CMD_TICK: begin
                    scan.enable = ENABLE_WIDTH'(1) << scan_index;
                    if (mode_flag) begin
                        scan.segments = symbol_segments(symbol_store[scan_index]);
                    end else begin
                        scan.segments = digit_segments(digit_store[scan_index]);
                        if (scan_index == 1) scan.segments = scan.segments | POINT_BIT;
                    end
                    scan.mode = mode_flag;
                    expected_scans.push_back(scan);
                    scan_index = (scan_index + 1) % DIGIT_SLOTS;
                end
                CMD_SET_NUMBER: begin
                    rest = value;
                    for (int i = 0; i < DIGIT_SLOTS; i++) begin
                        digit_store[i] = 4'(rest % 10);
                        rest = rest / 10;
                    end
                end
                CMD_PUSH: shift_in(code);
                CMD_POP: begin
                    for (int i = 0; i < DIGIT_SLOTS - 1; i++) symbol_store[i] = symbol_store[i + 1];
                    symbol_store[DIGIT_SLOTS - 1] = BLANK_CODE;
                end
                CMD_CLEAR: clear_symbols();
                CMD_LOAD: begin
                    if (first) begin
                        clear_symbols();
                        load_count = 0;
                    end
                    if (load_count < DIGIT_SLOTS) begin
                        shift_in(code);
                        load_count++;
                    end
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string field, logic [31:0] want, logic [31:0] got);
            $display("%0t: mismatch on %s, expected 0x%0h, got 0x%0h", $time, field, want, got);
            mismatches++;
        endtask

        task check_scan(logic [ENABLE_WIDTH-1:0] enable, logic [SEG_WIDTH-1:0] segments,
                        logic mode);
            scan_t want;
            if (expected_scans.size() == 0) begin
                report_mismatch("unexpected scan strobe", 32'd0, {enable, segments, mode});
                return;
            end
            want = expected_scans.pop_front();
            scans_checked++;
            if (enable !== want.enable)     report_mismatch("digit_enable", want.enable, enable);
            if (segments !== want.segments) report_mismatch("segment_pattern", want.segments,
                                                            segments);
            if (mode !== want.mode)         report_mismatch("display_mode", want.mode, mode);
        endtask

        function int pending();
            return expected_scans.size();
        endfunction

    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [CMD_WIDTH-1:0]    command;
    logic [NUM_WIDTH-1:0]    number_value;
    logic [CODE_WIDTH-1:0]   symbol_code;
    logic                    first_of_load;
    logic                    mode_select;
    logic                    mode_write;
    logic                    result_strobe;
    logic [ENABLE_WIDTH-1:0] digit_enable;
    logic [SEG_WIDTH-1:0]    segment_pattern;
    logic                    display_mode;

    display_scoreboard #(DIGITS) board;
    int unsigned                 items_sent;
    int unsigned                 cycle_count;
    bit                          quiet_stretch;

    multiplexed_seven_segment_driver_unit #(
        .DIGIT_COUNT(DIGITS)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .number_value   (number_value),
        .symbol_code    (symbol_code),
        .first_of_load  (first_of_load),
        .mode_select    (mode_select),
        .mode_write     (mode_write),
        .result_strobe  (result_strobe),
        .digit_enable   (digit_enable),
        .segment_pattern(segment_pattern),
        .display_mode   (display_mode)
    );

    // 12 ns clock period.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Both sides of the block are observed at the rising edge, before any flop in the
    // block updates. A transaction is accepted when start is high and busy is low.
    // The prediction is noted first, although a scan can never come out in the same
    // cycle as its own tick, since the tick passes through the queue and the result registers.
    always @(posedge clk)
    begin
        if (rst_n && board != null) begin
            if (start && !busy) begin
                board.note_command(command, number_value, symbol_code, first_of_load,
                                   mode_select, mode_write);
            end
            if (result_strobe) begin
                board.check_scan(digit_enable, segment_pattern, display_mode);
            end
        end
    end

    // Watchdog: a hung handshake or a lost scan ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Watchdog expired after %0d cycles with %0d scans outstanding.",
                     cycle_count, board.pending());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // While start is low the payload ports carry junk, which the block must ignore.
    function automatic void scramble_payload();
        command       = CMD_WIDTH'($urandom);
        number_value  = $urandom;
        symbol_code   = CODE_WIDTH'($urandom);
        first_of_load = 1'($urandom);
        mode_select   = 1'($urandom);
        mode_write    = 1'($urandom);
    endfunction

    // Presents one transaction at the falling edge and holds it until a rising edge
    // sees busy low. Start stays high on return, so the next call can follow
    // back-to-back without dropping it.
    task automatic send_command(input logic [CMD_WIDTH-1:0] cmd, input logic [NUM_WIDTH-1:0] value,
                                input logic [CODE_WIDTH-1:0] code, input logic first,
                                input logic sel, input logic wr);
        @(negedge clk);
        start         = 1'b1;
        command       = cmd;
        number_value  = value;
        symbol_code   = code;
        first_of_load = first;
        mode_select   = sel;
        mode_write    = wr;
        do @(posedge clk); while (busy);
        // A spare code without a mode write changes nothing, so it is not counted.
        if (cmd <= CMD_LOAD || wr) items_sent++;
    endtask

    task automatic idle_for(input int cycles);
        if (cycles > 0) begin
            @(negedge clk);
            start = 1'b0;
            scramble_payload();
            repeat (cycles - 1) begin
                @(negedge clk);
                scramble_payload();
            end
        end
    endtask

    // Most gaps are zero or short; a few are long enough to let the queue run dry.
    task automatic random_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet_stretch || roll < 60) idle_for(0);
        else if (roll < 90)             idle_for($urandom_range(1, 3));
        else if (roll < 98)             idle_for($urandom_range(4, 12));
        else                            idle_for($urandom_range(20, 60));
    endtask

    // Holds the sender off until every predicted scan has come out.
    task automatic drain_scans();
        @(negedge clk);
        start = 1'b0;
        scramble_payload();
        while (board.pending() != 0) @(posedge clk);
    endtask

    // Valid digit and symbol codes dominate; the rest are arbitrary bytes.
    function automatic logic [CODE_WIDTH-1:0] pick_code();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)      return CODE_WIDTH'($urandom_range(0, 9));
        else if (roll < 75) return CODE_WIDTH'($urandom_range(SYMBOL_FIRST, SYMBOL_LAST));
        else                return CODE_WIDTH'($urandom);
    endfunction

    // Mixes full-range values with ones that fit in six digits and the edges around
    // one million and the top of the range.
    function automatic logic [NUM_WIDTH-1:0] pick_number();
        case ($urandom_range(0, 5))
            0, 1:    return $urandom;
            2:       return $urandom_range(0, 999_999);
            3:       return $urandom_range(0, 99);
            default: begin
                case ($urandom_range(0, 3))
                    0:       return 32'd0;
                    1:       return 32'd999_999;
                    2:       return 32'd1_000_000;
                    default: return 32'hffff_ffff;
                endcase
            end
        endcase
    endfunction

    // A load sequence is normally one element flagged first followed by the rest.
    // Occasionally it is broken: the first flag is missing or shows up mid-sequence.
    task automatic send_load_sequence();
        int  length;
        bit  broken;
        length = $urandom_range(1, 9);
        broken = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < length; k++) begin
            send_command(CMD_LOAD, $urandom, pick_code(),
                         broken ? 1'($urandom) : (k == 0), 1'($urandom),
                         ($urandom_range(0, 7) == 0));
            random_gap();
        end
    endtask

    // Ticks dominate so that scans come often and walk every digit in both modes.
    task automatic send_random_command();
        int   roll;
        logic sel;
        logic wr;
        roll = $urandom_range(0, 99);
        sel  = 1'($urandom);
        wr   = ($urandom_range(0, 3) == 0);
        if (roll < 45) begin
            send_command(CMD_TICK, $urandom, CODE_WIDTH'($urandom), 1'($urandom), sel, wr);
        end else if (roll < 55) begin
            send_command(CMD_SET_NUMBER, pick_number(), CODE_WIDTH'($urandom), 1'($urandom),
                         sel, wr);
        end else if (roll < 68) begin
            send_command(CMD_PUSH, $urandom, pick_code(), 1'($urandom), sel, wr);
        end else if (roll < 75) begin
            send_command(CMD_POP, $urandom, CODE_WIDTH'($urandom), 1'($urandom), sel, wr);
        end else if (roll < 79) begin
            send_command(CMD_CLEAR, $urandom, CODE_WIDTH'($urandom), 1'($urandom), sel, wr);
        end else if (roll < 82) begin
            send_command(roll[0] ? CMD_SPARE_HIGH : CMD_SPARE_LOW, $urandom,
                         CODE_WIDTH'($urandom), 1'($urandom), sel, wr);
        end else begin
            send_load_sequence();
            return;
        end
        random_gap();
    endtask

    // A short directed sequence: both number extremes, every symbol, an unknown code,
    // a load longer than the display, a load element without its first flag, pop,
    // push, clear, mode writes on spare codes and on a tick, and full scans in both modes.
    task automatic run_directed();
        // Reset state: digit 0 of an all-zero number.
        send_command(CMD_TICK, 32'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        // The top of the range keeps only its low six digits, 967295.
        send_command(CMD_SET_NUMBER, 32'hffff_ffff, 8'd0, 1'b0, 1'b0, 1'b0);
        repeat (DIGITS) send_command(CMD_TICK, 32'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        // Switch to info mode along with the first load element.
        send_command(CMD_LOAD, 32'd0, 8'h81, 1'b1, 1'b1, 1'b1);
        send_command(CMD_LOAD, 32'd0, 8'h82, 1'b0, 1'b0, 1'b0);
        send_command(CMD_LOAD, 32'd0, 8'h83, 1'b0, 1'b0, 1'b0);
        send_command(CMD_LOAD, 32'd0, 8'h84, 1'b0, 1'b0, 1'b0);
        send_command(CMD_LOAD, 32'd0, SYMBOL_LAST, 1'b0, 1'b0, 1'b0);
        send_command(CMD_LOAD, 32'd0, 8'h0a, 1'b0, 1'b0, 1'b0);
        // A seventh element goes beyond the display and is dropped.
        send_command(CMD_LOAD, 32'd0, 8'h07, 1'b0, 1'b0, 1'b0);
        repeat (DIGITS) send_command(CMD_TICK, 32'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        // Without a first flag the full load count still blocks this element.
        send_command(CMD_LOAD, 32'd0, 8'h09, 1'b0, 1'b0, 1'b0);
        send_command(CMD_POP, 32'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        send_command(CMD_TICK, 32'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        send_command(CMD_PUSH, 32'd0, 8'hff, 1'b0, 1'b0, 1'b0);
        send_command(CMD_PUSH, 32'd0, SYMBOL_FIRST, 1'b0, 1'b0, 1'b0);
        send_command(CMD_TICK, 32'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        send_command(CMD_CLEAR, 32'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        send_command(CMD_TICK, 32'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        // Spare codes act only through their mode write.
        send_command(CMD_SPARE_LOW, 32'd0, 8'd0, 1'b0, 1'b0, 1'b1);
        send_command(CMD_TICK, 32'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        send_command(CMD_SPARE_HIGH, 32'd0, 8'd0, 1'b0, 1'b1, 1'b1);
        // A mode write on the tick itself is applied before the digit is shown.
        send_command(CMD_TICK, 32'd0, 8'd0, 1'b0, 1'b0, 1'b1);
        send_command(CMD_SET_NUMBER, 32'd0, 8'd0, 1'b0, 1'b0, 1'b0);
    endtask

    initial
    begin
        int unsigned next_drain;
        // Every input is known from time zero; reset is held low at first and released at a falling edge.
        rst_n         = 1'b0;
        start         = 1'b0;
        cycle_count   = 0;
        items_sent    = 0;
        quiet_stretch = 1'b0;
        scramble_payload();
        board = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();

        // The random phase alternates stretches with gaps and stretches without them,
        // and periodically holds the sender off until every predicted scan has come out.
        next_drain = items_sent + DRAIN_EVERY;
        while (items_sent < ITEM_GOAL) begin
            quiet_stretch = ((items_sent / 100) % 4 == 3);
            send_random_command();
            if (items_sent >= next_drain) begin
                drain_scans();
                next_drain = items_sent + DRAIN_EVERY;
            end
        end

        // Wait for the last scans, then give any trailing command time to retire.
        drain_scans();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d transactions (%0d ticks, %0d set number, %0d push, %0d pop, %0d load).",
                 items_sent, board.command_counts[CMD_TICK], board.command_counts[CMD_SET_NUMBER],
                 board.command_counts[CMD_PUSH], board.command_counts[CMD_POP],
                 board.command_counts[CMD_LOAD]);
        $display("Checked %0d scans in number and info modes; %0d mismatches found.",
                 board.scans_checked, board.mismatches);
        if (board.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- multiplexed_seven_segment_driver_unit.f -----
+incdir+hw/rtl
hw/rtl/ssd_pkg.sv
hw/rtl/ssd_front.sv
hw/rtl/ssd_queue.sv
hw/rtl/ssd_back.sv
hw/rtl/multiplexed_seven_segment_driver_unit.sv
hw/rtl/ssd_checker.sv
tb/tb.sv
